@@ hw/rtl/obs_pkg.sv @@
// ----------------------------------------------------------------------------
// obs_pkg
// Types, constants and helper functions shared by the orthonormal basis block.
// ----------------------------------------------------------------------------
package obs_pkg;

    localparam int W_MIN    = 31;
    localparam int N_STEPS  = 31;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] hint_x;
        logic signed [31:0] hint_y;
        logic signed [31:0] hint_z;
    } t_item;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic               valid_res;
    } t_res;

    function automatic logic [63:0] f_mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // round half away from zero, drop 30 fraction bits
    function automatic logic signed [63:0] f_rshr30(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] q;
        m = f_mag64(v);
        q = (m + 64'd536870912) >> 30;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

@@ hw/rtl/obs_stream_if.sv @@
// ----------------------------------------------------------------------------
// obs_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface obs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/obs_norm.sv @@
// ----------------------------------------------------------------------------
// obs_norm
// Pipelined vector normalizer: scale, square sum, bit-serial square root
// stages and restoring divide stages, producing Q2.30 unit components.
// ----------------------------------------------------------------------------
module obs_norm #(
    parameter int W_SIDE = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_vld,
    input  logic signed [63:0]      i_vec [3],
    input  logic [W_SIDE-1:0]       i_side,
    output logic                    o_vld,
    output logic signed [31:0]      o_vec [3],
    output logic [W_SIDE-1:0]       o_side
);

    localparam int NS = obs_pkg::N_STEPS;

    // stage A: magnitudes
    logic              r_a_vld;
    logic [63:0]       r_a_mag [3];
    logic              r_a_neg [3];
    logic [W_SIDE-1:0] r_a_side;
    // stage B: maximum
    logic              r_b_vld;
    logic [63:0]       r_b_max;
    logic [63:0]       r_b_mag [3];
    logic              r_b_neg [3];
    logic [W_SIDE-1:0] r_b_side;
    // stage C: leading one
    logic              r_c_vld;
    logic [5:0]        r_c_p;
    logic              r_c_zero;
    logic [63:0]       r_c_mag [3];
    logic              r_c_neg [3];
    logic [W_SIDE-1:0] r_c_side;
    // stage D: scaled components
    logic              r_d_vld;
    logic [29:0]       r_d_u [3];
    logic              r_d_zero;
    logic              r_d_neg [3];
    logic [W_SIDE-1:0] r_d_side;
    // stage E: squares
    logic              r_e_vld;
    logic [59:0]       r_e_sq [3];
    logic [29:0]       r_e_u [3];
    logic              r_e_zero;
    logic              r_e_neg [3];
    logic [W_SIDE-1:0] r_e_side;
    // square root stages
    logic              r_q_vld  [NS+1];
    logic [61:0]       r_q_n    [NS+1];
    logic [32:0]       r_q_rem  [NS+1];
    logic [30:0]       r_q_root [NS+1];
    logic [29:0]       r_q_u    [NS+1][3];
    logic              r_q_neg  [NS+1][3];
    logic              r_q_zero [NS+1];
    logic [W_SIDE-1:0] r_q_side [NS+1];
    // divide stages
    logic              r_v_vld  [NS+1];
    logic [60:0]       r_v_n    [NS+1][3];
    logic [31:0]       r_v_rem  [NS+1][3];
    logic [30:0]       r_v_q    [NS+1][3];
    logic [30:0]       r_v_d    [NS+1];
    logic              r_v_neg  [NS+1][3];
    logic              r_v_zero [NS+1];
    logic [W_SIDE-1:0] r_v_side [NS+1];
    // output
    logic              r_o_vld;
    logic signed [31:0] r_o_vec [3];
    logic [W_SIDE-1:0] r_o_side;

    logic [63:0] n_max;
    logic [5:0]  n_p;
    logic [5:0]  n_shr;
    logic [5:0]  n_shl;
    logic [63:0] n_sh [3];
    logic [60:0] n_num [3];

    always_comb begin
        n_max = r_a_mag[0];
        if (r_a_mag[1] > n_max) begin
            n_max = r_a_mag[1];
        end
        if (r_a_mag[2] > n_max) begin
            n_max = r_a_mag[2];
        end
    end

    always_comb begin
        n_p = '0;
        for (int b = 0; b < 64; b++) begin
            if (r_b_max[b]) begin
                n_p = 6'(b);
            end
        end
    end

    always_comb begin
        n_shr = r_c_p - 6'd29;
        n_shl = 6'd29 - r_c_p;
        for (int c = 0; c < 3; c++) begin
            n_sh[c] = (r_c_p >= 6'd30) ? (r_c_mag[c] >> n_shr) : (r_c_mag[c] << n_shl);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_num[c] = {1'b0, r_q_u[NS][c], 30'd0} + 61'(r_q_root[NS] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_q_vld[0] <= 1'b0;
            r_v_vld[0] <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_q_vld[0] <= r_e_vld;
            r_v_vld[0] <= r_q_vld[NS];
            r_o_vld <= r_v_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_a_mag[c] <= obs_pkg::f_mag64(i_vec[c]);
                r_a_neg[c] <= i_vec[c][63];
                r_b_mag[c] <= r_a_mag[c];
                r_b_neg[c] <= r_a_neg[c];
                r_c_mag[c] <= r_b_mag[c];
                r_c_neg[c] <= r_b_neg[c];
                r_d_u[c]   <= n_sh[c][29:0];
                r_d_neg[c] <= r_c_neg[c];
                r_e_sq[c]  <= r_d_u[c] * r_d_u[c];
                r_e_u[c]   <= r_d_u[c];
                r_e_neg[c] <= r_d_neg[c];
                r_q_u[0][c]   <= r_e_u[c];
                r_q_neg[0][c] <= r_e_neg[c];
                r_v_n[0][c]   <= n_num[c];
                r_v_rem[0][c] <= 32'(n_num[c][60:31]);
                r_v_q[0][c]   <= '0;
                r_v_neg[0][c] <= r_q_neg[NS][c];
                r_o_vec[c] <= r_v_zero[NS] ? 32'sd0 :
                              r_v_neg[NS][c] ? -$signed({1'b0, r_v_q[NS][c]}) :
                              $signed({1'b0, r_v_q[NS][c]});
            end
            r_a_side <= i_side;
            r_b_max  <= n_max;
            r_b_side <= r_a_side;
            r_c_p    <= n_p;
            r_c_zero <= (r_b_max == 64'd0);
            r_c_side <= r_b_side;
            r_d_zero <= r_c_zero;
            r_d_side <= r_c_side;
            r_e_zero <= r_d_zero;
            r_e_side <= r_d_side;
            r_q_n[0]    <= 62'(r_e_sq[0]) + 62'(r_e_sq[1]) + 62'(r_e_sq[2]);
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            r_q_zero[0] <= r_e_zero;
            r_q_side[0] <= r_e_side;
            r_v_d[0]    <= r_q_root[NS];
            r_v_zero[0] <= r_q_zero[NS];
            r_v_side[0] <= r_q_side[NS];
            r_o_side    <= r_v_side[NS];
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        localparam int BI = 2 * (NS - 1 - j);
        logic [34:0] n_rem;
        logic [34:0] n_trial;
        logic        n_ge;

        always_comb begin
            n_rem   = {r_q_rem[j], r_q_n[j][BI+1 -: 2]};
            n_trial = {2'b00, r_q_root[j], 2'b01};
            n_ge    = (n_rem >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_q_vld[j+1] <= r_q_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q_n[j+1]    <= r_q_n[j];
                r_q_rem[j+1]  <= n_ge ? 33'(n_rem - n_trial) : n_rem[32:0];
                r_q_root[j+1] <= {r_q_root[j][29:0], n_ge};
                r_q_u[j+1]    <= r_q_u[j];
                r_q_neg[j+1]  <= r_q_neg[j];
                r_q_zero[j+1] <= r_q_zero[j];
                r_q_side[j+1] <= r_q_side[j];
            end
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_div
        localparam int BI = NS - 1 - j;
        logic [32:0] n_srem [3];
        logic        n_ge   [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_srem[c] = {r_v_rem[j][c], r_v_n[j][c][BI]};
                n_ge[c]   = (n_srem[c] >= {2'b00, r_v_d[j]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_vld[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_v_vld[j+1] <= r_v_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                for (int c = 0; c < 3; c++) begin
                    r_v_rem[j+1][c] <= n_ge[c] ? 32'(n_srem[c] - {2'b00, r_v_d[j]})
                                               : n_srem[c][31:0];
                    r_v_q[j+1][c]   <= {r_v_q[j][c][29:0], n_ge[c]};
                end
                r_v_n[j+1]    <= r_v_n[j];
                r_v_d[j+1]    <= r_v_d[j];
                r_v_neg[j+1]  <= r_v_neg[j];
                r_v_zero[j+1] <= r_v_zero[j];
                r_v_side[j+1] <= r_v_side[j];
            end
        end
    end

    assign o_vld  = r_o_vld;
    assign o_vec  = r_o_vec;
    assign o_side = r_o_side;

endmodule

@@ hw/rtl/orthonormal_basis_from_segment.sv @@
// ----------------------------------------------------------------------------
// orthonormal_basis_from_segment
// Builds a 3x3 orthonormal basis (cross, transverse, edge columns) from a
// segment and a hint direction, with up and forward as fallback hints.
//
//   channel   | dir | payload                          | transfer when
//   i_item    | in  | start, end, hint (Q16.16)        | valid & ready
//   o_res     | out | m00..m22 (Q2.30), valid_res      | valid & ready
//   i_cfg_*   | in  | min_length (UQ15.16)             | i_cfg_we
//
// One item enters per cycle while the result is not held; the two
// normalizers each have 31 square root steps and 31 divide steps.
// Reset clears all valid bits and loads min_length with 66.
// A held result stalls every stage together; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_segment (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    obs_stream_if.sink                    i_item,
    obs_stream_if.source                  o_res,
    input  logic                          i_cfg_we,
    input  logic [obs_pkg::W_MIN-1:0]     i_cfg_wdata
);

    localparam int W_SIDE1 = 97;
    localparam int W_SIDE2 = 97;

    logic                      w_adv;
    logic [obs_pkg::W_MIN-1:0] r_min;
    logic [61:0]               r_min_sq;
    obs_pkg::t_item            w_in;

    // S1
    logic               r1_vld;
    logic signed [32:0] r1_edge [3];
    logic signed [31:0] r1_hint [3];
    // S2
    logic               r2_vld;
    logic               r2_big;
    logic [61:0]        r2_sq [3];
    logic signed [32:0] r2_edge [3];
    logic signed [31:0] r2_hint [3];
    // S3
    logic               r3_vld;
    logic               r3_short;
    logic signed [63:0] r3_edge [3];
    logic signed [31:0] r3_hint [3];

    logic               w_n1_vld;
    logic signed [31:0] w_e [3];
    logic [W_SIDE1-1:0] w_n1_side;
    logic signed [31:0] w_n1_hint [3];
    logic               w_n1_short;

    // T1
    logic               rt1_vld;
    logic signed [63:0] rt1_hp [3];
    logic signed [31:0] rt1_e [3];
    logic signed [31:0] rt1_hint [3];
    logic               rt1_short;
    // T2
    logic               rt2_vld;
    logic signed [63:0] rt2_d [3];
    logic signed [31:0] rt2_e [3];
    logic signed [31:0] rt2_h [3][3];
    logic               rt2_short;
    // T3
    logic               rt3_vld;
    logic [61:0]        rt3_phi [3][3];
    logic [62:0]        rt3_plo [3][3];
    logic               rt3_neg [3][3];
    logic signed [31:0] rt3_e [3];
    logic signed [31:0] rt3_h [3][3];
    logic               rt3_short;
    // T4
    logic               rt4_vld;
    logic signed [63:0] rt4_t [3][3];
    logic signed [31:0] rt4_e [3];
    logic               rt4_short;
    // T5
    logic               rt5_vld;
    logic [61:0]        rt5_sq [3][3];
    logic               rt5_big [3];
    logic signed [63:0] rt5_t [3][3];
    logic signed [31:0] rt5_e [3];
    logic               rt5_short;
    // T6
    logic               rt6_vld;
    logic signed [63:0] rt6_t [3];
    logic signed [31:0] rt6_e [3];
    logic               rt6_ok;

    logic               w_n2_vld;
    logic signed [31:0] w_tv [3];
    logic [W_SIDE2-1:0] w_n2_side;
    logic signed [31:0] w_n2_e [3];
    logic               w_n2_ok;

    // C1
    logic               rc_vld;
    logic signed [63:0] rc_pa [3];
    logic signed [63:0] rc_pb [3];
    logic signed [31:0] rc_tv [3];
    logic signed [31:0] rc_e [3];
    logic               rc_ok;
    // output
    logic               r_out_vld;
    obs_pkg::t_res      r_out;
    obs_pkg::t_res      n_out;

    logic [32:0]        n_emag [3];
    logic [63:0]        n_esum;
    logic [63:0]        n_ud [3];
    logic [30:0]        n_ue [3];
    logic [63:0]        n_p [3][3];
    logic signed [63:0] n_sp [3][3];
    logic [63:0]        n_tm [3][3];
    logic [33:0]        n_t16 [3][3];
    logic [63:0]        n_tsum [3];
    logic               n_tok [3];
    logic signed [63:0] n_c [3];

    assign w_adv        = !r_out_vld || o_res.ready;
    assign i_item.ready = w_adv;
    assign w_in         = i_item.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= 31'd66;
            r_min_sq <= 62'd4356;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            r_min_sq <= 62'(r_min) * 62'(r_min);
        end
    end

    always_comb begin
        n_esum = '0;
        for (int i = 0; i < 3; i++) begin
            n_emag[i] = r1_edge[i][32] ? 33'(-r1_edge[i]) : 33'(r1_edge[i]);
            n_esum    = n_esum + 64'(r2_sq[i]);
        end
        for (int k = 0; k < 3; k++) begin
            n_ud[k] = obs_pkg::f_mag64(rt2_d[k]);
        end
        for (int i = 0; i < 3; i++) begin
            n_ue[i] = rt2_e[i][31] ? 31'(-rt2_e[i]) : 31'(rt2_e[i]);
        end
        for (int k = 0; k < 3; k++) begin
            n_tsum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                n_p[k][i]  = {rt3_phi[k][i], 2'b00}
                             + 64'((64'(rt3_plo[k][i]) + 64'd536870912) >> 30);
                n_sp[k][i] = rt3_neg[k][i] ? -$signed(n_p[k][i]) : $signed(n_p[k][i]);
                n_tm[k][i] = obs_pkg::f_mag64(rt4_t[k][i]);
                n_t16[k][i] = 34'((n_tm[k][i] + 64'd536870912) >> 30);
                n_tsum[k]  = n_tsum[k] + 64'(rt5_sq[k][i]);
            end
            n_tok[k] = rt5_big[k] || !(n_tsum[k] < 64'(r_min_sq));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            rt1_vld <= 1'b0;
            rt2_vld <= 1'b0;
            rt3_vld <= 1'b0;
            rt4_vld <= 1'b0;
            rt5_vld <= 1'b0;
            rt6_vld <= 1'b0;
            rc_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld  <= i_item.valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            rt1_vld <= w_n1_vld;
            rt2_vld <= rt1_vld;
            rt3_vld <= rt2_vld;
            rt4_vld <= rt3_vld;
            rt5_vld <= rt4_vld;
            rt6_vld <= rt5_vld;
            rc_vld  <= w_n2_vld;
            r_out_vld <= rc_vld;
        end
    end

    // edge and its length test
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_edge[0] <= 33'(w_in.end_x) - 33'(w_in.start_x);
            r1_edge[1] <= 33'(w_in.end_y) - 33'(w_in.start_y);
            r1_edge[2] <= 33'(w_in.end_z) - 33'(w_in.start_z);
            r1_hint[0] <= w_in.hint_x;
            r1_hint[1] <= w_in.hint_y;
            r1_hint[2] <= w_in.hint_z;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 62'(n_emag[i][30:0]) * 62'(n_emag[i][30:0]);
            end
            r2_big  <= (n_emag[0][32:31] != 2'b00) || (n_emag[1][32:31] != 2'b00)
                       || (n_emag[2][32:31] != 2'b00);
            r2_edge <= r1_edge;
            r2_hint <= r1_hint;
            r3_short <= !r2_big && (n_esum < 64'(r_min_sq));
            for (int i = 0; i < 3; i++) begin
                r3_edge[i] <= 64'(r2_edge[i]);
            end
            r3_hint <= r2_hint;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_hint_unpack
        assign w_n1_hint[i] = w_n1_side[96-32*i -: 32];
    end
    assign w_n1_short = w_n1_side[0];

    obs_norm #(.W_SIDE(W_SIDE1)) u_norm_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r3_vld),
        .i_vec   (r3_edge),
        .i_side  ({r3_hint[0], r3_hint[1], r3_hint[2], r3_short}),
        .o_vld   (w_n1_vld),
        .o_vec   (w_e),
        .o_side  (w_n1_side)
    );

    // transverse attempts: hint, up, forward
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                rt1_hp[i] <= 64'(w_n1_hint[i]) * 64'(w_e[i]);
            end
            rt1_e     <= w_e;
            rt1_hint  <= w_n1_hint;
            rt1_short <= w_n1_short;

            rt2_d[0] <= rt1_hp[0] + rt1_hp[1] + rt1_hp[2];
            rt2_d[1] <= 64'(rt1_e[1]) <<< 16;
            rt2_d[2] <= 64'(rt1_e[2]) <<< 16;
            rt2_e    <= rt1_e;
            rt2_h[0] <= rt1_hint;
            rt2_h[1][0] <= '0;
            rt2_h[1][1] <= obs_pkg::ONE_Q16;
            rt2_h[1][2] <= '0;
            rt2_h[2][0] <= '0;
            rt2_h[2][1] <= '0;
            rt2_h[2][2] <= obs_pkg::ONE_Q16;
            rt2_short <= rt1_short;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    rt3_phi[k][i] <= 62'(n_ud[k][63:32]) * 62'(n_ue[i]);
                    rt3_plo[k][i] <= 63'(n_ud[k][31:0]) * 63'(n_ue[i]);
                    rt3_neg[k][i] <= rt2_d[k][63] != rt2_e[i][31];
                end
            end
            rt3_e     <= rt2_e;
            rt3_h     <= rt2_h;
            rt3_short <= rt2_short;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    rt4_t[k][i] <= ($signed(64'(rt3_h[k][i])) <<< 30) - n_sp[k][i];
                end
            end
            rt4_e     <= rt3_e;
            rt4_short <= rt3_short;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    rt5_sq[k][i] <= 62'(n_t16[k][i][30:0]) * 62'(n_t16[k][i][30:0]);
                end
                rt5_big[k] <= (n_t16[k][0][33:31] != 3'd0) || (n_t16[k][1][33:31] != 3'd0)
                              || (n_t16[k][2][33:31] != 3'd0);
            end
            rt5_t     <= rt4_t;
            rt5_e     <= rt4_e;
            rt5_short <= rt4_short;

            if (n_tok[0]) begin
                rt6_t <= rt5_t[0];
            end else if (n_tok[1]) begin
                rt6_t <= rt5_t[1];
            end else begin
                rt6_t <= rt5_t[2];
            end
            rt6_ok <= !rt5_short && (n_tok[0] || n_tok[1] || n_tok[2]);
            rt6_e  <= rt5_e;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_e_unpack
        assign w_n2_e[i] = w_n2_side[96-32*i -: 32];
    end
    assign w_n2_ok = w_n2_side[0];

    obs_norm #(.W_SIDE(W_SIDE2)) u_norm_trans (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (rt6_vld),
        .i_vec   (rt6_t),
        .i_side  ({rt6_e[0], rt6_e[1], rt6_e[2], rt6_ok}),
        .o_vld   (w_n2_vld),
        .o_vec   (w_tv),
        .o_side  (w_n2_side)
    );

    // cross product and result
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c[k] = obs_pkg::f_rshr30(rc_pa[k] - rc_pb[k]);
            if (n_c[k] > 64'sd1073741824) begin
                n_c[k] = 64'sd1073741824;
            end else if (n_c[k] < -64'sd1073741824) begin
                n_c[k] = -64'sd1073741824;
            end
        end
        n_out.m00 = 32'(-n_c[0]);
        n_out.m01 = rc_tv[0];
        n_out.m02 = rc_e[0];
        n_out.m10 = 32'(n_c[1]);
        n_out.m11 = rc_tv[1];
        n_out.m12 = rc_e[1];
        n_out.m20 = 32'(n_c[2]);
        n_out.m21 = rc_tv[2];
        n_out.m22 = rc_e[2];
        n_out.valid_res = 1'b1;
        if (!rc_ok) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rc_pa[0] <= 64'(w_tv[1]) * 64'(w_n2_e[2]);
            rc_pb[0] <= 64'(w_tv[2]) * 64'(w_n2_e[1]);
            rc_pa[1] <= 64'(w_tv[2]) * 64'(w_n2_e[0]);
            rc_pb[1] <= 64'(w_tv[0]) * 64'(w_n2_e[2]);
            rc_pa[2] <= 64'(w_tv[0]) * 64'(w_n2_e[1]);
            rc_pb[2] <= 64'(w_tv[1]) * 64'(w_n2_e[0]);
            rc_tv <= w_tv;
            rc_e  <= w_n2_e;
            rc_ok <= w_n2_ok;
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

@@ sim/orthonormal_basis_from_segment_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orthonormal_basis_from_segment_tb
// Streams segments and hint directions into the basis builder under several
// min_length settings and checks every matrix and valid flag, most against a
// fixed-point Gram-Schmidt predictor. Both channels idle at random; the
// result side holds off once for a long stretch so the pipeline fills.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_segment_tb;

    typedef longint t_vec3 [3];

    localparam int N_RANDOM_PER_PHASE = 100;
    localparam int N_PHASES           = 6;
    localparam int N_DIRECTED         = 12;
    localparam int DRAIN_CYCLES       = 200;
    localparam int LONG_HOLD          = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_wdata;

    obs_stream_if #(.T(obs_pkg::t_item)) item_if ();
    obs_stream_if #(.T(obs_pkg::t_res))  res_if ();

    orthonormal_basis_from_segment dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    longint unsigned min_len;
    obs_pkg::t_res   basis_q [$];
    int              n_errors;
    int              n_sent;
    int              n_got;
    bit              long_hold_done;

    obs_pkg::t_item dir_items [N_DIRECTED];
    bit             dir_typed [N_DIRECTED];
    obs_pkg::t_res  dir_basis [N_DIRECTED];

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint round_q30(longint v);
        longint unsigned m;
        m = (abs64(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit is_short(t_vec3 v, longint unsigned lim);
        longint unsigned s, m;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = abs64(v[i]);
            if (m >= (64'd1 << 31)) return 1'b0;
            s += m * m;
        end
        return s < lim * lim;
    endfunction

    function automatic t_vec3 unit_vec(t_vec3 v);
        longint unsigned u [3];
        longint unsigned m, s, r, q;
        int              rs, ls;
        t_vec3           e;
        m = 0;
        s = 0;
        rs = 0;
        ls = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = abs64(v[i]);
            if (u[i] > m) m = u[i];
        end
        if (m == 0) begin
            e = '{0, 0, 0};
            return e;
        end
        while ((m >> rs) >= (64'd1 << 30)) rs++;
        while (((m >> rs) << ls) < (64'd1 << 29)) ls++;
        for (int i = 0; i < 3; i++) begin
            u[i] = (u[i] >> rs) << ls;
            s += u[i] * u[i];
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((u[i] << 30) + (r >> 1)) / r;
            e[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return e;
    endfunction

    function automatic longint scale_q30(longint d, longint e);
        longint unsigned ud, ue, hi, lo, p;
        ud = abs64(d);
        ue = abs64(e);
        hi = ud >> 32;
        lo = ud & 64'hFFFF_FFFF;
        p  = ((hi * ue) << 2) + ((lo * ue + (64'd1 << 29)) >> 30);
        return ((d < 0) != (e < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint cross_q30(longint a, longint b, longint c, longint d);
        longint v;
        v = round_q30(a * b - c * d);
        if (v > (64'sd1 << 30)) v = 64'sd1 << 30;
        if (v < -(64'sd1 << 30)) v = -(64'sd1 << 30);
        return v;
    endfunction

    function automatic obs_pkg::t_res predict_basis(obs_pkg::t_item it,
                                                    longint unsigned lim);
        t_vec3         seg_d, e, h, t, t16, tv;
        longint        c0, c1, c2, d;
        bit            found;
        obs_pkg::t_res r;
        r = '0;
        seg_d[0] = longint'(it.end_x) - longint'(it.start_x);
        seg_d[1] = longint'(it.end_y) - longint'(it.start_y);
        seg_d[2] = longint'(it.end_z) - longint'(it.start_z);
        if (is_short(seg_d, lim)) return r;
        e = unit_vec(seg_d);
        found = 1'b0;
        for (int k = 0; k < 3 && !found; k++) begin
            if (k == 0) begin
                h = '{longint'(it.hint_x), longint'(it.hint_y), longint'(it.hint_z)};
            end else begin
                h = '{0, (k == 1) ? 65536 : 0, (k == 2) ? 65536 : 0};
            end
            d = h[0] * e[0] + h[1] * e[1] + h[2] * e[2];
            for (int i = 0; i < 3; i++) begin
                t[i]   = h[i] * (64'sd1 << 30) - scale_q30(d, e[i]);
                t16[i] = round_q30(t[i]);
            end
            found = !is_short(t16, lim);
        end
        if (!found) return r;
        tv = unit_vec(t);
        c0 = cross_q30(tv[1], e[2], tv[2], e[1]);
        c1 = cross_q30(tv[2], e[0], tv[0], e[2]);
        c2 = cross_q30(tv[0], e[1], tv[1], e[0]);
        r.m00 = 32'(-c0);    r.m01 = 32'(tv[0]); r.m02 = 32'(e[0]);
        r.m10 = 32'(c1);     r.m11 = 32'(tv[1]); r.m12 = 32'(e[1]);
        r.m20 = 32'(c2);     r.m21 = 32'(tv[2]); r.m22 = 32'(e[2]);
        r.valid_res = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic obs_pkg::t_item seg(int sx, int sy, int sz, int ex, int ey, int ez,
                                           int hx, int hy, int hz);
        obs_pkg::t_item it;
        it = '{sx, sy, sz, ex, ey, ez, hx, hy, hz};
        return it;
    endfunction

    function automatic int rand_coord();
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            2: case ($urandom_range(0, 2))
                   0: v = 32'h8000_0000;
                   1: v = 32'h7FFF_FFFF;
                   default: v = 0;
               endcase
            3: begin
                v = int'($urandom >> $urandom_range(1, 31));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = int'($urandom_range(0, 400)) - 200;
        endcase
        return v;
    endfunction

    function automatic obs_pkg::t_item rand_segment();
        obs_pkg::t_item it;
        int             kind;
        it = seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord());
        kind = $urandom_range(0, 9);
        case (kind)
            6: begin
                it.hint_x = it.end_x - it.start_x;
                it.hint_y = it.end_y - it.start_y;
                it.hint_z = it.end_z - it.start_z;
            end
            7: begin
                it.end_x = it.start_x + int'($urandom_range(0, 200)) - 100;
                it.end_y = it.start_y + int'($urandom_range(0, 200)) - 100;
                it.end_z = it.start_z + int'($urandom_range(0, 200)) - 100;
            end
            8: begin
                it.hint_x = 0;
                it.hint_y = $urandom_range(0, 1) ? 65536 : 0;
                it.hint_z = 0;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic check_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin
        obs_pkg::t_res got, want;
        int            stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (n_got >= 300 && n_got < 360) stall = 0;
            else stall = $urandom_range(0, 4);
            if (n_got == 150 && !long_hold_done) begin
                stall = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            forever begin
                @(negedge i_clk);
                if (res_if.valid) break;
                @(posedge i_clk);
            end
            got = res_if.data;
            @(posedge i_clk);
            n_got++;
            if (basis_q.size() == 0) begin
                $error("result transfer with no basis expected");
                n_errors++;
            end else begin
                want = basis_q.pop_front();
                check_field("m00", want.m00, got.m00);
                check_field("m01", want.m01, got.m01);
                check_field("m02", want.m02, got.m02);
                check_field("m10", want.m10, got.m10);
                check_field("m11", want.m11, got.m11);
                check_field("m12", want.m12, got.m12);
                check_field("m20", want.m20, got.m20);
                check_field("m21", want.m21, got.m21);
                check_field("m22", want.m22, got.m22);
                check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
            end
        end
    end

    // ------------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------------
    task automatic send_segment(obs_pkg::t_item it, bit typed, obs_pkg::t_res typed_basis);
        int gap;
        gap = (n_sent >= 200 && n_sent < 280) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        forever begin
            @(negedge i_clk);
            if (item_if.ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        n_sent++;
        basis_q.push_back(typed ? typed_basis : predict_basis(it, min_len));
    endtask

    task automatic write_min_length(longint unsigned v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 31'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        min_len = v;
        @(posedge i_clk);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        obs_pkg::t_res   unit_xy;
        longint unsigned phase_len [N_PHASES];
        n_errors = 0;
        n_sent = 0;
        n_got = 0;
        long_hold_done = 1'b0;
        min_len = 66;
        phase_len = '{66, 0, 31'h7FFF_FFFF, 1, 0, 65536};
        phase_len[4] = $urandom & 32'h0001_FFFF;

        unit_xy = '0;
        unit_xy.m20 = -(32'sd1 << 30);
        unit_xy.m11 = 32'sd1 << 30;
        unit_xy.m02 = 32'sd1 << 30;
        unit_xy.valid_res = 1'b1;

        // zero edge, unit x with hint up, just short, exactly at threshold,
        // hint along edge, edge and hint up, extremes, zero and min hints
        dir_items[0]  = seg(0, 0, 0, 0, 0, 0, 65536, 0, 0);
        dir_items[1]  = seg(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
        dir_items[2]  = seg(0, 0, 0, 65, 0, 0, 0, 65536, 0);
        dir_items[3]  = seg(0, 0, 0, 66, 0, 0, 0, 65536, 0);
        dir_items[4]  = seg(0, 0, 0, 65536, 0, 0, 65536, 0, 0);
        dir_items[5]  = seg(0, 0, 0, 0, 65536, 0, 0, 65536, 0);
        dir_items[6]  = seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        dir_items[7]  = seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 1, 1, 1);
        dir_items[8]  = seg(100, 200, 300, -400, 500, 600, 0, 0, 0);
        dir_items[9]  = seg(0, 0, 0, 3, -4, 12, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        dir_items[10] = seg(0, 0, 65536, 0, 0, -65536, 32'h7FFF_FFFF, -1, 0);
        dir_items[11] = seg(5, 5, 5, 5, 5, 5, 0, 0, 0);
        dir_typed = '{1, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 1};
        for (int i = 0; i < N_DIRECTED; i++) dir_basis[i] = '0;
        dir_basis[1] = unit_xy;
        dir_basis[4] = unit_xy;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) write_min_length(phase_len[p]);
            for (int i = 0; i < N_DIRECTED; i++)
                send_segment(dir_items[i], p == 0 && dir_typed[i], dir_basis[i]);
            for (int i = 0; i < N_RANDOM_PER_PHASE; i++)
                send_segment(rand_segment(), 1'b0, '0);
            drain();
        end

        if (n_errors == 0) begin
            $display("orthonormal_basis_from_segment_tb passed");
        end else begin
            $display("orthonormal_basis_from_segment_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("orthonormal_basis_from_segment_tb failed");
        $finish;
    end

endmodule
